### src/apc_pkg.sv
// Shared types, codes and constants of the alert pattern controller.
`timescale 1ns / 1ps

package apc_pkg;

	// Number of alert states with a pattern word of their own.
	localparam int ALERT_STATES = 4;
	localparam int STATE_IDX_W  = (ALERT_STATES > 1) ? $clog2(ALERT_STATES) : 1;

	// Field widths of one command transfer.
	localparam int KIND_W   = 3;
	localparam int STATE_W  = 3;
	localparam int MODE_W   = 3;
	localparam int LEVEL_W  = 8;
	localparam int TONE_W   = 16;
	localparam int MS_W     = 16;

	// Configuration port.
	localparam int CFG_IDX_W = 8;
	localparam int WORD_W    = 61;
	localparam int LED_CNT_W = 10;

	// Command kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_TICK     = 3'd0,
		KIND_TRIGGER  = 3'd1,
		KIND_LED_MODE = 3'd2,
		KIND_MOTOR    = 3'd3,
		KIND_BUZZER   = 3'd4,
		KIND_STOP     = 3'd5
	} kind_t;

	// LED modes; codes 5 to 7 carry no meaning.
	localparam logic [MODE_W-1:0] LED_OFF       = 3'd0;
	localparam logic [MODE_W-1:0] LED_SOLID     = 3'd1;
	localparam logic [MODE_W-1:0] LED_SLOW      = 3'd2;
	localparam logic [MODE_W-1:0] LED_FAST      = 3'd3;
	localparam logic [MODE_W-1:0] LED_HEARTBEAT = 3'd4;

	// Blink periods in ticks.
	localparam logic [LED_CNT_W-1:0] SLOW_MS      = 10'd1000;
	localparam logic [LED_CNT_W-1:0] FAST_MS      = 10'd250;
	localparam logic [LED_CNT_W-1:0] PULSE_ON_MS  = 10'd100;
	localparam logic [LED_CNT_W-1:0] PULSE_OFF_MS = 10'd900;

	// Layout of one packed alert pattern word.
	typedef struct packed {
		logic [MS_W-1:0]   buz_ms;
		logic [TONE_W-1:0] tone;
		logic              buz_en;
		logic [MS_W-1:0]   vib_ms;
		logic [6:0]        vib_level;
		logic              vib_en;
		logic [MODE_W-1:0] led_mode;
		logic              led_en;
	} alert_word_t;

	// Reset contents of the pattern words, state 0 first.
	localparam logic [WORD_W-1:0] WORD_RESET [4] = '{
		61'd3, 61'd5, 61'd820821, 61'd17594333798550679
	};

	// Step command for the LED unit.
	typedef struct packed {
		logic              tick;
		logic              start;
		logic [MODE_W-1:0] mode;
	} led_cmd_t;

	// Step command for a motor or buzzer timer.
	typedef struct packed {
		logic            tick;
		logic            start;
		logic            on;
		logic [MS_W-1:0] ms;
	} tmr_cmd_t;

endpackage

### src/apc_cmd_if.sv
// Command channel: ticks and commands with their payload fields.
`timescale 1ns / 1ps

interface apc_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [apc_pkg::KIND_W-1:0]   kind;
	logic [apc_pkg::STATE_W-1:0]  alert_state;
	logic [apc_pkg::MODE_W-1:0]   led_mode;
	logic [apc_pkg::LEVEL_W-1:0]  motor_level;
	logic [apc_pkg::TONE_W-1:0]   tone_hz;
	logic [apc_pkg::MS_W-1:0]     run_ms;

	modport source (output valid, kind, alert_state, led_mode, motor_level, tone_hz, run_ms,
		input ready);
	modport sink (input valid, kind, alert_state, led_mode, motor_level, tone_hz, run_ms,
		output ready);
endinterface

### src/apc_pin_if.sv
// Result channel: the three pin levels after each command transfer.
`timescale 1ns / 1ps

interface apc_pin_if;
	logic valid;
	logic ready;
	logic led_on;
	logic motor_on;
	logic buzzer_on;

	modport source (output valid, led_on, motor_on, buzzer_on, input ready);
	modport sink (input valid, led_on, motor_on, buzzer_on, output ready);
endinterface

### src/apc_cfg_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface apc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [apc_pkg::CFG_IDX_W-1:0]  index;
	logic [apc_pkg::WORD_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### src/apc_led.sv
// LED unit: mode register, blink countdown and pin level.
`timescale 1ns / 1ps

module apc_led (
	input  logic              clk,
	input  logic              arst_n,
	input  apc_pkg::led_cmd_t cmd,
	output logic              led_on
);
	import apc_pkg::*;

	logic                 level_q, level_d;
	logic [MODE_W-1:0]    mode_q, mode_d;
	logic [LED_CNT_W-1:0] cnt_q, cnt_d;

	always_comb begin
		level_d = level_q;
		mode_d  = mode_q;
		cnt_d   = cnt_q;
		if (cmd.start) begin
			mode_d = cmd.mode;
			cnt_d  = '0;
			case (cmd.mode) inside
				LED_OFF:                 level_d = 1'b0;
				LED_SOLID:               level_d = 1'b1;
				LED_SLOW, LED_HEARTBEAT: begin
					level_d = 1'b1;
					cnt_d   = SLOW_MS;
				end
				LED_FAST: begin
					level_d = 1'b1;
					cnt_d   = FAST_MS;
				end
				default:                 level_d = level_q;
			endcase
		end else if (cmd.tick && cnt_q != '0) begin
			cnt_d = cnt_q - 1'b1;
			if (cnt_q == LED_CNT_W'(1)) begin
				// Countdown expires: toggle and reload for the next phase.
				level_d = ~level_q;
				case (mode_q)
					LED_SLOW:      cnt_d = SLOW_MS;
					LED_FAST:      cnt_d = FAST_MS;
					LED_HEARTBEAT: cnt_d = level_d ? PULSE_ON_MS : PULSE_OFF_MS;
					default:       cnt_d = '0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			mode_q  <= LED_OFF;
			cnt_q   <= '0;
		end else begin
			level_q <= level_d;
			mode_q  <= mode_d;
			cnt_q   <= cnt_d;
		end
	end

	assign led_on = level_q;

endmodule

### src/apc_timer.sv
// Run timer for the motor or the buzzer: enable level and stop countdown.
`timescale 1ns / 1ps

module apc_timer (
	input  logic              clk,
	input  logic              arst_n,
	input  apc_pkg::tmr_cmd_t cmd,
	output logic              level
);
	import apc_pkg::*;

	logic            level_q, level_d;
	logic [MS_W-1:0] cnt_q, cnt_d;

	always_comb begin
		level_d = level_q;
		cnt_d   = cnt_q;
		if (cmd.start) begin
			level_d = cmd.on;
			cnt_d   = cmd.ms;
		end else if (cmd.tick && cnt_q != '0) begin
			cnt_d = cnt_q - 1'b1;
			if (cnt_q == MS_W'(1)) begin
				level_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			level_q <= level_d;
			cnt_q   <= cnt_d;
		end
	end

	assign level = level_q;

endmodule

### src/alert_pattern_controller_core.sv
// Top level of the alert pattern controller: command decode, pattern words, pin results.
`timescale 1ns / 1ps
// A command passes the input register, then the pin state registers, which offer its result.
// Throughput: one command per cycle unless results stall; the input register and the pin state
// registers form the two stages, and the pin state registers double as the result register.
// Reset: pins off, LED in off mode, all countdowns clear, pattern words at their reset values.
// Configuration writes are always accepted and take effect at once.

module alert_pattern_controller_core (
	input  logic       clk,
	input  logic       arst_n,
	apc_cmd_if.sink    cmd,
	apc_pin_if.source  pins,
	apc_cfg_if.sink    cfg
);
	import apc_pkg::*;

	// Input register stage. A command sits here until the pin state can take it.
	logic                valid_s1;
	logic [KIND_W-1:0]   kind_s1;
	logic [STATE_W-1:0]  state_s1;
	logic [MODE_W-1:0]   mode_s1;
	logic [LEVEL_W-1:0]  level_s1;
	logic [TONE_W-1:0]   tone_s1;
	logic [MS_W-1:0]     ms_s1;

	// The pin state only changes when a command advances, and every advance also loads a
	// new result, so the state registers themselves hold the pending result payload.
	logic out_valid_q;
	logic advance;

	// Pattern words, one per alert state.
	logic [WORD_W-1:0] alert_word_q [ALERT_STATES];
	alert_word_t       word;
	logic              state_ok;

	led_cmd_t led_cmd;
	tmr_cmd_t motor_cmd;
	tmr_cmd_t buzzer_cmd;

	assign advance   = valid_s1 && (!out_valid_q || pins.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			kind_s1  <= cmd.kind;
			state_s1 <= cmd.alert_state;
			mode_s1  <= cmd.led_mode;
			level_s1 <= cmd.motor_level;
			tone_s1  <= cmd.tone_hz;
			ms_s1    <= cmd.run_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pins.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Pattern word registers; writes beyond the list of states are dropped.
	for (genvar i = 0; i < ALERT_STATES; i++) begin : g_word
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				alert_word_q[i] <= WORD_RESET[i];
			end else if (cfg.valid && cfg.index == CFG_IDX_W'(i)) begin
				alert_word_q[i] <= cfg.data;
			end
		end
	end

	// States at or above the number of patterns leave the pins alone.
	assign state_ok = state_s1 < STATE_W'(ALERT_STATES);
	assign word     = alert_word_t'(alert_word_q[state_s1[STATE_IDX_W-1:0]]);

	// Command decode into steps for the LED unit and the two run timers.
	always_comb begin
		led_cmd    = '0;
		motor_cmd  = '0;
		buzzer_cmd = '0;
		if (advance) begin
			unique case (kind_t'(kind_s1))
				KIND_TICK: begin
					led_cmd.tick    = 1'b1;
					motor_cmd.tick  = 1'b1;
					buzzer_cmd.tick = 1'b1;
				end
				KIND_TRIGGER: begin
					if (state_ok) begin
						// A disabled part of the pattern stops that output.
						led_cmd.start    = 1'b1;
						led_cmd.mode     = word.led_en ? word.led_mode : LED_OFF;
						motor_cmd.start  = 1'b1;
						motor_cmd.on     = word.vib_en && (word.vib_level != '0);
						motor_cmd.ms     = word.vib_en ? word.vib_ms : '0;
						buzzer_cmd.start = 1'b1;
						buzzer_cmd.on    = word.buz_en && (word.tone != '0);
						buzzer_cmd.ms    = word.buz_en ? word.buz_ms : '0;
					end
				end
				KIND_LED_MODE: begin
					led_cmd.start = 1'b1;
					led_cmd.mode  = mode_s1;
				end
				KIND_MOTOR: begin
					motor_cmd.start = 1'b1;
					motor_cmd.on    = level_s1 != '0;
					motor_cmd.ms    = ms_s1;
				end
				KIND_BUZZER: begin
					buzzer_cmd.start = 1'b1;
					buzzer_cmd.on    = tone_s1 != '0;
					buzzer_cmd.ms    = ms_s1;
				end
				KIND_STOP: begin
					led_cmd.start    = 1'b1;
					led_cmd.mode     = LED_OFF;
					motor_cmd.start  = 1'b1;
					buzzer_cmd.start = 1'b1;
				end
				default: begin
					// Unused kinds only report the current pins.
				end
			endcase
		end
	end

	apc_led u_led (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (led_cmd),
		.led_on (pins.led_on)
	);

	apc_timer u_motor (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (motor_cmd),
		.level  (pins.motor_on)
	);

	apc_timer u_buzzer (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (buzzer_cmd),
		.level  (pins.buzzer_on)
	);

	assign pins.valid = out_valid_q;

endmodule

### dv/apc_pin_checker.sv
// Checker: predicts the pin levels after every command transfer and compares the results.
`timescale 1ns / 1ps

module apc_pin_checker (
	input  logic clk,
	input  logic arst_n,
	apc_cmd_if   cmd,
	apc_pin_if   pins,
	apc_cfg_if   cfg,
	output int   failures,
	output int   pending,
	output int   checked
);
	import apc_pkg::*;

	typedef struct packed {
		logic led;
		logic motor;
		logic buzzer;
	} pin_set_t;

	alert_word_t            pattern [ALERT_STATES];
	logic                   led_lvl;
	logic [MODE_W-1:0]      led_mode_q;
	logic [LED_CNT_W-1:0]   led_cnt;
	logic                   motor_lvl;
	logic [MS_W-1:0]        motor_cnt;
	logic                   buzzer_lvl;
	logic [MS_W-1:0]        buzzer_cnt;
	pin_set_t               expected_pins [$];
	pin_set_t               want;
	int                     fail_count;
	int                     match_count;

	task automatic note_mismatch(input string what);
		$display("%0t ns: pin mismatch: %s", $time, what);
		fail_count++;
	endtask

	task automatic led_start(input logic [MODE_W-1:0] mode);
		led_mode_q = mode;
		led_cnt    = '0;
		case (mode)
			LED_OFF:                 led_lvl = 1'b0;
			LED_SOLID:               led_lvl = 1'b1;
			LED_SLOW, LED_HEARTBEAT: begin
				led_lvl = 1'b1;
				led_cnt = SLOW_MS;
			end
			LED_FAST: begin
				led_lvl = 1'b1;
				led_cnt = FAST_MS;
			end
			// Modes without meaning keep the pin as it is.
			default: ;
		endcase
	endtask

	task automatic advance_ms();
		if (led_cnt != 0) begin
			led_cnt = led_cnt - 1'b1;
			if (led_cnt == 0) begin
				led_lvl = ~led_lvl;
				case (led_mode_q)
					LED_SLOW:      led_cnt = SLOW_MS;
					LED_FAST:      led_cnt = FAST_MS;
					LED_HEARTBEAT: led_cnt = led_lvl ? PULSE_ON_MS : PULSE_OFF_MS;
					default:       ;
				endcase
			end
		end
		if (motor_cnt != 0) begin
			motor_cnt = motor_cnt - 1'b1;
			if (motor_cnt == 0)
				motor_lvl = 1'b0;
		end
		if (buzzer_cnt != 0) begin
			buzzer_cnt = buzzer_cnt - 1'b1;
			if (buzzer_cnt == 0)
				buzzer_lvl = 1'b0;
		end
	endtask

	task automatic apply_pattern(input logic [STATE_W-1:0] st);
		alert_word_t w;
		if (st < ALERT_STATES) begin
			w = pattern[st[STATE_IDX_W-1:0]];
			led_start(w.led_en ? w.led_mode : LED_OFF);
			motor_lvl  = w.vib_en && (w.vib_level != 0);
			motor_cnt  = w.vib_en ? w.vib_ms : '0;
			buzzer_lvl = w.buz_en && (w.tone != 0);
			buzzer_cnt = w.buz_en ? w.buz_ms : '0;
		end
	endtask

	task automatic predict_pins();
		case (cmd.kind)
			KIND_TICK:     advance_ms();
			KIND_TRIGGER:  apply_pattern(cmd.alert_state);
			KIND_LED_MODE: led_start(cmd.led_mode);
			KIND_MOTOR: begin
				motor_lvl = (cmd.motor_level != 0);
				motor_cnt = cmd.run_ms;
			end
			KIND_BUZZER: begin
				buzzer_lvl = (cmd.tone_hz != 0);
				buzzer_cnt = cmd.run_ms;
			end
			KIND_STOP: begin
				led_start(LED_OFF);
				motor_lvl  = 1'b0;
				motor_cnt  = '0;
				buzzer_lvl = 1'b0;
				buzzer_cnt = '0;
			end
			default: ;
		endcase
		expected_pins.push_back('{led_lvl, motor_lvl, buzzer_lvl});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ALERT_STATES; i++)
				pattern[i] = WORD_RESET[i];
			led_lvl     = 1'b0;
			led_mode_q  = LED_OFF;
			led_cnt     = '0;
			motor_lvl   = 1'b0;
			motor_cnt   = '0;
			buzzer_lvl  = 1'b0;
			buzzer_cnt  = '0;
			expected_pins.delete();
			fail_count  = 0;
			match_count = 0;
		end else begin
			// Results leave only after their command was taken, so compare before predicting.
			if (pins.valid && pins.ready) begin
				if (expected_pins.size() == 0) begin
					note_mismatch("pin result with no command waiting");
				end else begin
					want = expected_pins.pop_front();
					if (pins.led_on !== want.led)
						note_mismatch($sformatf("led_on %b, expected %b", pins.led_on, want.led));
					if (pins.motor_on !== want.motor)
						note_mismatch($sformatf("motor_on %b, expected %b",
							pins.motor_on, want.motor));
					if (pins.buzzer_on !== want.buzzer)
						note_mismatch($sformatf("buzzer_on %b, expected %b",
							pins.buzzer_on, want.buzzer));
					match_count++;
				end
			end
			if (cfg.valid && cfg.ready && cfg.index < ALERT_STATES)
				pattern[cfg.index[STATE_IDX_W-1:0]] = cfg.data;
			if (cmd.valid && cmd.ready)
				predict_pins();
		end
		failures <= fail_count;
		pending  <= expected_pins.size();
		checked  <= match_count;
	end

endmodule

### dv/tb_alert_pattern_controller_core.sv
// Testbench top: stimulus, configuration phases and verdict for the alert pattern controller.
`timescale 1ns / 1ps

module tb_alert_pattern_controller_core;
	import apc_pkg::*;

	// Command kinds the block does not use; they must leave the pins alone.
	localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

	// LED mode codes without meaning.
	localparam logic [MODE_W-1:0] LED_SPARE_LO = 3'd5;
	localparam logic [MODE_W-1:0] LED_SPARE_HI = 3'd7;

	// Alert states as carried in a trigger command.
	localparam logic [STATE_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATE_W-1:0] ST_WARNING   = 3'd1;
	localparam logic [STATE_W-1:0] ST_CRITICAL  = 3'd2;
	localparam logic [STATE_W-1:0] ST_EMERGENCY = 3'd3;
	localparam logic [STATE_W-1:0] ST_UNUSED_LO = 3'd4;
	localparam logic [STATE_W-1:0] ST_UNUSED_HI = 3'd7;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_WORD_OK        = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_WARNING   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_CRITICAL  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_EMERGENCY = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO    = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI    = 8'd255;

	localparam int STALL_CYCLES = 300;
	localparam int RANDOM_ITEMS = 100;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [STATE_W-1:0] alert_state;
		logic [MODE_W-1:0]  led_mode;
		logic [LEVEL_W-1:0] motor_level;
		logic [TONE_W-1:0]  tone_hz;
		logic [MS_W-1:0]    run_ms;
	} cmd_item_t;

	logic clk;
	logic arst_n;

	apc_cmd_if cmd ();
	apc_pin_if pins ();
	apc_cfg_if cfg ();

	int failures;
	int pending;
	int checked;

	// Idle rates in percent; written by the stimulus, read by the two drivers.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// A long result hold-off is requested by bumping this count.
	int stall_requests = 0;
	int stall_served   = 0;
	int stall_left     = 0;

	int n_items    = 0;
	int n_ticks    = 0;
	int n_triggers = 0;
	int n_writes   = 0;

	alert_pattern_controller_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pins   (pins),
		.cfg    (cfg)
	);

	apc_pin_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.pins     (pins),
		.cfg      (cfg),
		.failures (failures),
		.pending  (pending),
		.checked  (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Safety net: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("FAIL alert_pattern_controller_core");
		$finish;
	end

	// Result side: random back-pressure, or one long hold-off when the stimulus asks for it.
	// The hold-off is counted here so that the sender keeps offering items meanwhile and
	// the block fills up and stalls its command input.
	initial begin
		pins.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				pins.ready <= 1'b0;
			end else if (stall_served != stall_requests) begin
				stall_served = stall_requests;
				stall_left   = STALL_CYCLES - 1;
				pins.ready <= 1'b0;
			end else begin
				pins.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic cmd_item_t mk(input logic [KIND_W-1:0] kind,
			input logic [STATE_W-1:0] st, input logic [MODE_W-1:0] mode,
			input logic [LEVEL_W-1:0] level, input logic [TONE_W-1:0] tone,
			input logic [MS_W-1:0] ms);
		cmd_item_t it;
		it = '{kind, st, mode, level, tone, ms};
		return it;
	endfunction

	// Run times are mostly short so that countdowns run out within a tick run, but the
	// whole 16-bit range still turns up now and then.
	function automatic logic [MS_W-1:0] rand_ms();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return '0;
		else if (roll < 70)
			return MS_W'($urandom_range(30, 1));
		return MS_W'($urandom);
	endfunction

	// Every payload field is randomised whatever the kind, so that the unused ones toggle too.
	function automatic cmd_item_t rand_item(input logic [KIND_W-1:0] kind);
		cmd_item_t it;
		it.kind        = kind;
		it.alert_state = ($urandom_range(4) == 0) ? STATE_W'($urandom_range(7, 4))
			: STATE_W'($urandom_range(3));
		it.led_mode    = ($urandom_range(6) == 0) ? MODE_W'($urandom_range(7, 5))
			: MODE_W'($urandom_range(4));
		it.motor_level = ($urandom_range(4) == 0) ? '0 : LEVEL_W'($urandom);
		it.tone_hz     = ($urandom_range(4) == 0) ? '0 : TONE_W'($urandom);
		it.run_ms      = rand_ms();
		return it;
	endfunction

	function automatic logic [KIND_W-1:0] pick_command();
		int roll;
		roll = $urandom_range(99);
		if (roll < 35)
			return KIND_TRIGGER;
		else if (roll < 60)
			return KIND_LED_MODE;
		else if (roll < 75)
			return KIND_MOTOR;
		else if (roll < 90)
			return KIND_BUZZER;
		else if (roll < 95)
			return KIND_STOP;
		return ($urandom_range(1) == 0) ? KIND_SPARE_A : KIND_SPARE_B;
	endfunction

	function automatic alert_word_t rand_pattern();
		alert_word_t w;
		w.led_en    = $urandom_range(3) != 0;
		w.led_mode  = MODE_W'($urandom);
		w.vib_en    = $urandom_range(3) != 0;
		w.vib_level = ($urandom_range(4) == 0) ? '0 : 7'($urandom);
		w.vib_ms    = rand_ms();
		w.buz_en    = $urandom_range(3) != 0;
		w.tone      = ($urandom_range(4) == 0) ? '0 : TONE_W'($urandom);
		w.buz_ms    = rand_ms();
		return w;
	endfunction

	// One command transfer, preceded by a random number of idle cycles.
	task automatic send_item(input cmd_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid       <= 1'b1;
		cmd.kind        <= it.kind;
		cmd.alert_state <= it.alert_state;
		cmd.led_mode    <= it.led_mode;
		cmd.motor_level <= it.motor_level;
		cmd.tone_hz     <= it.tone_hz;
		cmd.run_ms      <= it.run_ms;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		n_items++;
		if (it.kind == KIND_TICK)
			n_ticks++;
		if (it.kind == KIND_TRIGGER)
			n_triggers++;
	endtask

	// Leaves cfg.valid high; the caller lowers it after the last write of a batch.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		n_writes++;
	endtask

	task automatic load_patterns(input logic [WORD_W-1:0] w_ok, input logic [WORD_W-1:0] w_warn,
			input logic [WORD_W-1:0] w_crit, input logic [WORD_W-1:0] w_emer);
		write_reg(REG_WORD_OK, w_ok);
		write_reg(REG_WORD_WARNING, w_warn);
		write_reg(REG_WORD_CRITICAL, w_crit);
		write_reg(REG_WORD_EMERGENCY, w_emer);
		cfg.valid <= 1'b0;
	endtask

	// Drains the block before a register write: every result in, then a few spare edges.
	task automatic wait_drained();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Random traffic in episodes: a few commands set up a pattern, then a run of ticks lets
	// blinking and countdowns play out. Now and then a motor, buzzer or unused command lands
	// inside a run without disturbing the LED, so long runs still reach blink toggles.
	task automatic run_episodes(input int count);
		int goal;
		int n_setup;
		int run_len;
		int roll;
		goal = n_items + count;
		while (n_items < goal) begin
			n_setup = $urandom_range(3, 1);
			repeat (n_setup)
				send_item(rand_item(pick_command()));
			roll = $urandom_range(99);
			if (roll < 70)
				run_len = $urandom_range(20);
			else if (roll < 95)
				run_len = $urandom_range(120, 21);
			else
				run_len = $urandom_range(320, 250);
			repeat (run_len) begin
				roll = $urandom_range(19);
				if (roll == 0)
					send_item(rand_item(KIND_MOTOR));
				else if (roll == 1)
					send_item(rand_item(KIND_BUZZER));
				else if (roll == 2)
					send_item(rand_item(KIND_SPARE_A));
				else
					send_item(rand_item(KIND_TICK));
			end
		end
	endtask

	initial begin
		cmd_item_t directed [$];

		arst_n          <= 1'b0;
		cmd.valid       <= 1'b0;
		cmd.kind        <= KIND_TICK;
		cmd.alert_state <= '0;
		cmd.led_mode    <= LED_OFF;
		cmd.motor_level <= '0;
		cmd.tone_hz     <= '0;
		cmd.run_ms      <= '0;
		cfg.valid       <= 1'b0;
		cfg.index       <= REG_WORD_OK;
		cfg.data        <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, on the pattern words as they come out of reset. It walks the LED
		// modes including the meaningless ones, untimed and timed motor and buzzer runs at the
		// field extremes, zero level and zero tone with a run time, every alert state plus
		// out-of-range ones, stop all, and the unused kinds.
		send_idle_pct = 34;
		recv_idle_pct = 53;
		directed = '{
			mk(KIND_TICK, ST_OK, LED_OFF, 8'd0, 16'd0, 16'd0),
			mk(KIND_LED_MODE, ST_OK, LED_SOLID, 8'd0, 16'd0, 16'd0),
			mk(KIND_LED_MODE, ST_OK, LED_FAST, 8'd0, 16'd0, 16'd0),
			mk(KIND_LED_MODE, ST_OK, LED_SPARE_LO, 8'd0, 16'd0, 16'd0),
			mk(KIND_TICK, ST_OK, LED_OFF, 8'd0, 16'd0, 16'd0),
			mk(KIND_LED_MODE, ST_OK, LED_SPARE_HI, 8'd0, 16'd0, 16'd0),
			mk(KIND_LED_MODE, ST_OK, LED_OFF, 8'd0, 16'd0, 16'd0),
			mk(KIND_MOTOR, ST_OK, LED_OFF, 8'd255, 16'd0, 16'd0),
			mk(KIND_MOTOR, ST_OK, LED_OFF, 8'd1, 16'd0, 16'd2),
			mk(KIND_TICK, ST_OK, LED_OFF, 8'd0, 16'd0, 16'd0),
			mk(KIND_TICK, ST_OK, LED_OFF, 8'd0, 16'd0, 16'd0),
			mk(KIND_MOTOR, ST_OK, LED_OFF, 8'd0, 16'd0, 16'd3),
			mk(KIND_BUZZER, ST_OK, LED_OFF, 8'd0, 16'hFFFF, 16'hFFFF),
			mk(KIND_BUZZER, ST_OK, LED_OFF, 8'd0, 16'd0, 16'd1),
			mk(KIND_BUZZER, ST_OK, LED_OFF, 8'd0, 16'd1, 16'd1),
			mk(KIND_TICK, ST_OK, LED_OFF, 8'd0, 16'd0, 16'd0),
			mk(KIND_TRIGGER, ST_OK, LED_OFF, 8'd0, 16'd0, 16'd0),
			mk(KIND_TRIGGER, ST_WARNING, LED_OFF, 8'd0, 16'd0, 16'd0),
			mk(KIND_TRIGGER, ST_CRITICAL, LED_OFF, 8'd0, 16'd0, 16'd0),
			mk(KIND_TRIGGER, ST_EMERGENCY, LED_OFF, 8'd0, 16'd0, 16'd0),
			mk(KIND_TRIGGER, ST_UNUSED_LO, LED_OFF, 8'd0, 16'd0, 16'd0),
			mk(KIND_TRIGGER, ST_UNUSED_HI, LED_OFF, 8'd0, 16'd0, 16'd0),
			mk(KIND_STOP, ST_UNUSED_HI, LED_SPARE_HI, 8'd255, 16'hFFFF, 16'hFFFF),
			mk(KIND_SPARE_A, ST_OK, LED_SOLID, 8'd255, 16'hFFFF, 16'd0),
			mk(KIND_SPARE_B, ST_OK, LED_SOLID, 8'd255, 16'hFFFF, 16'd0),
			mk(KIND_LED_MODE, ST_OK, LED_HEARTBEAT, 8'd0, 16'd0, 16'd0),
			mk(KIND_LED_MODE, ST_OK, LED_SLOW, 8'd0, 16'd0, 16'd0)
		};
		foreach (directed[i])
			send_item(directed[i]);
		wait_drained();

		// First random phase: empty and full pattern words, sender idling less than receiver.
		// The writes to unmapped indexes must change nothing.
		write_reg(REG_UNMAPPED_LO, WORD_W'({$urandom, $urandom}));
		write_reg(REG_UNMAPPED_HI, '1);
		load_patterns('0, '1, rand_pattern(), rand_pattern());
		run_episodes(RANDOM_ITEMS);
		wait_drained();

		// Second random phase: fresh random patterns, idle rates swapped.
		send_idle_pct = 53;
		recv_idle_pct = 34;
		load_patterns(rand_pattern(), rand_pattern(), rand_pattern(), rand_pattern());
		run_episodes(RANDOM_ITEMS);
		wait_drained();

		// Third phase, no idling at all. It opens with a long result hold-off during which the
		// sender keeps pushing, so the block backs up and holds its command input.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_patterns('1, '0, rand_pattern(), rand_pattern());
		stall_requests++;
		repeat (40)
			send_item(rand_item(pick_command()));
		run_episodes(RANDOM_ITEMS - 40);

		// Blink soak: long enough for the pulse mode to leave its opening on phase and
		// reload for its off phase, while a timed motor run expires on the way.
		send_item(mk(KIND_LED_MODE, ST_OK, LED_HEARTBEAT, 8'd0, 16'd0, 16'd0));
		send_item(mk(KIND_MOTOR, ST_OK, LED_OFF, 8'd9, 16'd0, 16'd700));
		send_item(mk(KIND_BUZZER, ST_OK, LED_OFF, 8'd0, 16'd3, 16'd0));
		repeat (1005)
			send_item(rand_item(KIND_TICK));
		send_item(rand_item(KIND_STOP));
		wait_drained();
		repeat (20) @(posedge clk);

		$display("Run covered %0d command transfers (%0d ticks, %0d alert triggers),",
			n_items, n_ticks, n_triggers);
		$display("%0d register writes and %0d pin results checked over directed corners,",
			n_writes, checked);
		$display("two idling mixes, a long result hold-off and a blink soak.");
		if (failures == 0) begin
			$display("PASS alert_pattern_controller_core");
		end else begin
			$display("FAIL alert_pattern_controller_core");
		end
		$finish;
	end

endmodule
